// ----- rtl/normal_equation_accumulator_defines.svh -----
// Assertion macros for the checker file of the accumulator.
// No dependencies; included by nea_checker.sv.
`ifndef NORMAL_EQUATION_ACCUMULATOR_DEFINES_SVH
`define NORMAL_EQUATION_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define NEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masks the check.
`define NEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/nea_pkg.sv -----
// Shared types, sizes and codes of the normal equation accumulator.
// No dependencies; used by every module under rtl.
package nea_pkg;

  localparam int MAX_VARS  = 4;
  localparam int MAX_FUNCS = 2;
  localparam int ROW_W     = 2;
  localparam int COL_W     = 2;
  localparam int FUNC_W    = (MAX_FUNCS > 1) ? $clog2(MAX_FUNCS) : 1;
  localparam int CNT_W     = 3;
  localparam int ACC_W     = 64;
  localparam int PROD_W    = 48;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACCUM = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_VARS  = 1'b0;
  localparam logic CFG_FUNCS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_READ
  } state_t;

  // control from the sequencer to every lane
  typedef struct packed {
    logic             clear;
    logic             issue;
    logic [ROW_W-1:0] issue_row;
    logic [ROW_W-1:0] rd_row;
  } lane_ctl_t;

  // readout beat request from the sequencer to the output register
  typedef struct packed {
    logic             load;
    logic             which;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } emit_t;

  function automatic logic [CNT_W-1:0] clamp_vars(input logic [2:0] v);
    logic [CNT_W-1:0] r;
    if (v == 3'd0) begin
      r = CNT_W'(1);
    end else if (v > 3'(MAX_VARS)) begin
      r = CNT_W'(MAX_VARS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [1:0] clamp_funcs(input logic [1:0] v);
    logic [1:0] r;
    if (v == 2'd0) begin
      r = 2'd1;
    end else if (v > 2'(MAX_FUNCS)) begin
      r = 2'(MAX_FUNCS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/nea_lane.sv -----
// One accumulation lane: a*b*weight pipeline and a saturating column store.
// Depends on nea_pkg.
module nea_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  nea_pkg::lane_ctl_t        ctl,
  input  logic                      en,
  input  logic signed [15:0]        a,
  input  logic signed [15:0]        b,
  input  logic [15:0]               weight,
  output logic signed [63:0]        rd_data,
  output logic                      ovf
);
  import nea_pkg::*;

  logic signed [31:0]      p1;
  logic signed [PROD_W-1:0] p2;
  logic                    v1, v2;
  logic [ROW_W-1:0]        r1, r2;
  logic signed [ACC_W-1:0] col_store [MAX_VARS];
  logic [ROW_W-1:0]        rd_idx;
  logic signed [ACC_W-1:0] cur;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sat_val;
  logic                    sat_hit;
  logic signed [48:0]      p2_full;

  assign p2_full = p1 * $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
    end
    r1 <= ctl.issue_row;
    r2 <= r1;
    p1 <= a * b;
    p2 <= p2_full[PROD_W-1:0];
  end

  // single read port: the accumulate row wins while it is in flight
  assign rd_idx  = v2 ? r2 : ctl.rd_row;
  assign cur     = col_store[rd_idx];
  assign rd_data = cur;

  assign sum     = {cur[ACC_W-1], cur} + (ACC_W+1)'(p2);
  assign sat_hit = sum[ACC_W] != sum[ACC_W-1];

  always_comb begin
    if (!sat_hit) begin
      sat_val = sum[ACC_W-1:0];
    end else if (sum[ACC_W]) begin
      sat_val = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      ovf <= 1'b0;
      for (int i = 0; i < MAX_VARS; i++) begin
        col_store[i] <= '0;
      end
    end else if (v2 && en) begin
      col_store[r2] <= sat_val;
      if (sat_hit) begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/nea_ctrl.sv -----
// Sequencer: row issue for accumulate beats, entry walk for readout.
// Depends on nea_pkg.
module nea_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  logic [1:0]                op,
  input  logic [nea_pkg::CNT_W-1:0] nx,
  input  logic [1:0]                nf,
  input  logic                      out_free,
  output logic                      busy,
  output nea_pkg::lane_ctl_t        ctl,
  output nea_pkg::emit_t            emit
);
  import nea_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             rd_which;
  logic [ROW_W-1:0] rd_row;
  logic [COL_W-1:0] rd_col;
  logic             row_end, col_end, acc_done, is_last;

  assign row_end  = {1'b0, rd_row} == nx - CNT_W'(1);
  assign col_end  = rd_which ? (rd_col == COL_W'(nf - 2'd1))
                             : ({1'b0, rd_col} == nx - CNT_W'(1));
  assign is_last  = rd_which && row_end && col_end;
  assign acc_done = cnt == nx + CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && op == OP_ACCUM) begin
          state_next = ST_ACC;
        end else if (in_fire && op == OP_READ) begin
          state_next = ST_READ;
        end
      end
      ST_ACC: begin
        if (acc_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free && is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    ctl.clear     = 1'b0;
    ctl.issue     = 1'b0;
    ctl.issue_row = cnt[ROW_W-1:0];
    ctl.rd_row    = rd_row;
    emit.load     = 1'b0;
    emit.which    = rd_which;
    emit.row      = rd_row;
    emit.col      = rd_col;
    emit.last     = is_last;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        ctl.clear = in_fire && op == OP_CLEAR;
      end
      ST_ACC: begin
        ctl.issue = cnt < nx;
      end
      ST_READ: begin
        emit.load = out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      rd_which <= 1'b0;
      rd_row   <= '0;
      rd_col   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ACC) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (state != ST_READ) begin
        rd_which <= 1'b0;
        rd_row   <= '0;
        rd_col   <= '0;
      end else if (out_free) begin
        if (col_end) begin
          rd_col <= '0;
          if (row_end) begin
            rd_row   <= '0;
            rd_which <= 1'b1;
          end else begin
            rd_row <= rd_row + ROW_W'(1);
          end
        end else begin
          rd_col <= rd_col + COL_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/normal_equation_accumulator.sv -----
// Top level of the weighted least-squares normal equation accumulator.
// Depends on nea_pkg, nea_lane and nea_ctrl.
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_stall   op, x_first..x_fourth, f_first, f_second,
//                                 weight
//  out      out_valid / out_stall which_matrix, row, col, value, saturated,
//                                 last
//  cfg      cfg_we                cfg_index, cfg_data
//
// Clear zeroes both stores and overflow flags without stalling; accumulate
// holds in_stall after the beat while the clamped vars_in_use rows pass, one
// matrix row per cycle, through the two-multiplier lane pipeline.
// Readout gives one beat per cycle while out_stall is low.
// rst is synchronous: both stores, the overflow flag and the sizes reset.
// in_stall is high while an accumulate or readout is in progress.
module normal_equation_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [15:0] x_first,
  input  logic signed [15:0] x_second,
  input  logic signed [15:0] x_third,
  input  logic signed [15:0] x_fourth,
  input  logic signed [15:0] f_first,
  input  logic signed [15:0] f_second,
  input  logic [15:0]        weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               which_matrix,
  output logic [1:0]         row,
  output logic [1:0]         col,
  output logic signed [63:0] value,
  output logic               saturated,
  output logic               last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data
);
  import nea_pkg::*;

  logic [2:0]         vars_in_use;
  logic [1:0]         funcs_in_use;
  logic [CNT_W-1:0]   nx;
  logic [1:0]         nf;
  logic               in_fire;
  logic               busy;
  logic               out_free;
  lane_ctl_t          ctl;
  emit_t              emit;
  logic signed [15:0] x_q [MAX_VARS];
  logic signed [15:0] f_q [MAX_FUNCS];
  logic signed [15:0] x_in [MAX_VARS];
  logic signed [15:0] f_in [MAX_FUNCS];
  logic [15:0]        w_q;
  logic signed [15:0] a_sel;
  logic signed [63:0] mat_rd [MAX_VARS];
  logic signed [63:0] rhs_rd [MAX_FUNCS];
  logic [MAX_VARS-1:0]  mat_ovf;
  logic [MAX_FUNCS-1:0] rhs_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vars_in_use  <= 3'd4;
      funcs_in_use <= 2'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_VARS) begin
        vars_in_use <= cfg_data;
      end else if (cfg_index == CFG_FUNCS) begin
        funcs_in_use <= cfg_data[1:0];
      end
    end
  end

  assign nx = clamp_vars(vars_in_use);
  assign nf = clamp_funcs(funcs_in_use);

  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign x_in[0] = x_first;
  assign x_in[1] = x_second;
  assign x_in[2] = x_third;
  assign x_in[3] = x_fourth;
  assign f_in[0] = f_first;
  assign f_in[1] = f_second;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_q <= x_in;
      f_q <= f_in;
      w_q <= weight;
    end
  end

  assign a_sel = x_q[ctl.issue_row];

  nea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .op       (op),
    .nx       (nx),
    .nf       (nf),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl),
    .emit     (emit)
  );

  for (genvar l = 0; l < MAX_VARS; l++) begin : g_mat
    nea_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .en      (CNT_W'(l) < nx),
      .a       (a_sel),
      .b       (x_q[l]),
      .weight  (w_q),
      .rd_data (mat_rd[l]),
      .ovf     (mat_ovf[l])
    );
  end

  for (genvar k = 0; k < MAX_FUNCS; k++) begin : g_rhs
    nea_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .en      (2'(k) < nf),
      .a       (a_sel),
      .b       (f_q[k]),
      .weight  (w_q),
      .rd_data (rhs_rd[k]),
      .ovf     (rhs_ovf[k])
    );
  end

  // merge: pick the lane for this entry and register the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      which_matrix <= emit.which;
      row          <= emit.row;
      col          <= emit.col;
      last         <= emit.last;
      saturated    <= |{mat_ovf, rhs_ovf};
      if (emit.which) begin
        value <= rhs_rd[emit.col[FUNC_W-1:0]];
      end else begin
        value <= mat_rd[emit.col];
      end
    end
  end

endmodule

// ----- rtl/nea_checker.sv -----
// Port-level checks on the accumulator, bound to the top level.
// Depends on nea_pkg and normal_equation_accumulator_defines.svh.
`include "normal_equation_accumulator_defines.svh"

module nea_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         op,
  input logic               out_valid,
  input logic               out_stall,
  input logic               which_matrix,
  input logic [1:0]         col,
  input logic signed [63:0] value,
  input logic               last
);
  import nea_pkg::*;

  // a stalled output beat stays put
  `NEA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value), "out beat changed while stalled")

  // accumulate and readout both occupy the block after the beat
  `NEA_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && (op == OP_ACCUM || op == OP_READ), in_stall, "input not stalled after accumulate or readout beat")

  // right-side entries only carry function indexes
  `NEA_ASSERT_NOW(a_rhs_col, out_valid && which_matrix, col[1] == 1'b0, "right side column out of range")

  // a readout streams without gaps until its last entry
  `NEA_ASSERT_NEXT(a_stream, out_valid && !out_stall && !last, out_valid, "gap inside readout")

endmodule

bind normal_equation_accumulator nea_checker u_nea_checker (.*);
